// ===== hw/rtl/tors_pkg.sv =====
package tors_pkg;

	localparam int MAX_ITEMS   = 1024;
	localparam int CODE_BITS   = 63;
	localparam int NUM_BINS    = 8;
	localparam int STACK_DEPTH = 160;

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int STW = $clog2(STACK_DEPTH + 1);
	localparam int BW  = $clog2(NUM_BINS);

	localparam int THR_W   = 11;
	localparam int SHIFT_W = 6;
	localparam int LVL_W   = 5;
	localparam int IDX_W   = 32;
	localparam int POS_W   = 10;

	localparam logic [0:0] CFG_THR   = 1'b0;
	localparam logic [0:0] CFG_SHIFT = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(128);
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(60);

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic [IDX_W-1:0]     idx;
	} mem_word_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		mem_word_t     wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic             we;
		logic [AW-1:0]    waddr;
		logic [LVL_W-1:0] wdata;
	} lvl_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	typedef struct packed {
		logic [CW-1:0]      start;
		logic [CW-1:0]      len;
		logic signed [6:0]  shift;
		logic [LVL_W-1:0]   level;
		logic               buf_b;
	} stk_t;

	// three-bit digit at a non-negative shift
	function automatic logic [BW-1:0] digit_of(input logic [CODE_BITS-1:0] code,
		input logic signed [6:0] sh);
		logic [CODE_BITS:0] ext;
		ext = {1'b0, code} >> sh[5:0];
		return ext[BW-1:0];
	endfunction

endpackage

// ===== hw/rtl/tors_ram.sv =====
module tors_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/tors_engine.sv =====
module tors_engine import tors_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CW-1:0]      total,
	input  logic [THR_W-1:0]   thr,
	input  logic [SHIFT_W-1:0] start_sh,
	input  mem_word_t          a_rdata,
	input  mem_word_t          b_rdata,
	output ram_req_t           a_req,
	output ram_req_t           b_req,
	output lvl_req_t           lvl_req,
	output eng_stat_t          stat
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_ENTER  = 4'd2;
	localparam logic [3:0] S_COPY   = 4'd3;
	localparam logic [3:0] S_POP    = 4'd4;
	localparam logic [3:0] S_POPW   = 4'd5;
	localparam logic [3:0] S_COUNT  = 4'd6;
	localparam logic [3:0] S_PREFIX = 4'd7;
	localparam logic [3:0] S_SCAT   = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]        state_q;
	logic [CW-1:0]     total_q;
	logic [AW-1:0]     clr_q;
	stk_t              e_q;
	stk_t              n_q;
	logic              child_mode_q;
	logic [BW-1:0]     child_q;
	logic [STW-1:0]    top_q;
	logic [CW-1:0]     iss_q;
	logic              rv_s1;
	logic [AW-1:0]     wa_s1;
	logic [CW-1:0]     bins_q  [NUM_BINS];
	logic [CW-1:0]     cur_q   [NUM_BINS];
	logic [CW-1:0]     first_q [NUM_BINS];
	logic [CW-1:0]     off_q;
	logic [BW-1:0]     p_q;

	logic              stk_we;
	logic              stk_re;
	logic [SAW-1:0]    stk_raddr;
	stk_t              stk_rdata;
	stk_t              stk_wdata;

	logic              leaf;
	logic              go_next;
	logic              pass_done;
	logic              issue;
	logic [CW-1:0]     rd_addr;
	logic [BW-1:0]     nc;
	logic              more_child;
	mem_word_t         src_rdata;
	logic [BW-1:0]     dig;
	logic [STW-1:0]    top_dec;

	assign leaf = (32'(e_q.len) <= 32'(thr)) || (e_q.shift < 0) ||
		(top_q >= STW'(STACK_DEPTH));
	assign go_next = ((state_q == S_ENTER) &&
		((e_q.len == '0) || !leaf || e_q.buf_b)) ||
		((state_q == S_COPY) && pass_done);
	assign nc         = child_q + 1'b1;
	assign more_child = child_mode_q && (child_q != BW'(NUM_BINS - 1));
	assign top_dec    = top_q - 1'b1;

	// shared read sequencing for copy, count and scatter passes
	always_comb begin
		logic [CW-1:0] base;
		logic [CW-1:0] lim;
		base = (state_q == S_COPY) ? e_q.start : n_q.start;
		lim  = (state_q == S_COPY) ? e_q.len : n_q.len;
		issue     = (iss_q != lim);
		pass_done = !issue && !rv_s1;
		rd_addr   = base + iss_q;
	end

	assign src_rdata = n_q.buf_b ? b_rdata : a_rdata;
	assign dig       = digit_of(src_rdata.code, n_q.shift);

	// drive memory ports
	always_comb begin
		a_req   = '0;
		b_req   = '0;
		lvl_req = '0;
		stk_we  = 1'b0;
		stk_re  = 1'b0;
		stk_raddr = top_dec[SAW-1:0];
		stk_wdata = e_q;
		case (state_q)
			S_CLR: begin
				lvl_req.we    = 1'b1;
				lvl_req.waddr = clr_q;
			end
			S_ENTER: begin
				if (e_q.len != '0) begin
					lvl_req.we    = 1'b1;
					lvl_req.waddr = e_q.start[AW-1:0];
					lvl_req.wdata = e_q.level;
					stk_we        = !leaf;
				end
			end
			S_COPY: begin
				a_req.re    = issue;
				a_req.raddr = rd_addr[AW-1:0];
				b_req.we    = rv_s1;
				b_req.waddr = wa_s1;
				b_req.wdata = a_rdata;
			end
			S_POP: stk_re = (top_q != '0);
			S_COUNT, S_SCAT: begin
				a_req.raddr = rd_addr[AW-1:0];
				b_req.raddr = rd_addr[AW-1:0];
				a_req.re    = issue && !n_q.buf_b;
				b_req.re    = issue && n_q.buf_b;
				if (state_q == S_SCAT && rv_s1) begin
					a_req.we    = n_q.buf_b;
					b_req.we    = !n_q.buf_b;
					a_req.waddr = cur_q[dig][AW-1:0];
					b_req.waddr = cur_q[dig][AW-1:0];
					a_req.wdata = src_rdata;
					b_req.wdata = src_rdata;
				end
			end
			default: ;
		endcase
	end

	tors_ram #(.DEPTH(STACK_DEPTH), .WIDTH($bits(stk_t))) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (top_q[SAW-1:0]),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// payload of the pass pipeline
	always_ff @(posedge clk) begin
		wa_s1 <= rd_addr[AW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= '0;
			clr_q        <= '0;
			e_q          <= '0;
			n_q          <= '0;
			child_mode_q <= 1'b0;
			child_q      <= '0;
			top_q        <= '0;
			iss_q        <= '0;
			rv_s1        <= 1'b0;
			off_q        <= '0;
			p_q          <= '0;
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i]  <= '0;
				cur_q[i]   <= '0;
				first_q[i] <= '0;
			end
		end else begin
			// advance the read pipeline during passes
			if (state_q == S_COPY || state_q == S_COUNT || state_q == S_SCAT) begin
				rv_s1 <= issue;
				if (issue) iss_q <= iss_q + 1'b1;
			end
			if (go_next) begin
				if (more_child) begin
					child_q     <= nc;
					e_q.start   <= first_q[nc];
					e_q.len     <= bins_q[nc];
					state_q     <= S_ENTER;
				end else begin
					child_mode_q <= 1'b0;
					state_q      <= S_POP;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						total_q <= total;
						clr_q   <= '0;
						top_q   <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_ITEMS - 1)) begin
						e_q.start    <= '0;
						e_q.len      <= total_q;
						e_q.shift    <= {1'b0, start_sh};
						e_q.level    <= '0;
						e_q.buf_b    <= 1'b0;
						child_mode_q <= 1'b0;
						state_q      <= S_ENTER;
					end
				end
				S_ENTER: begin
					if (e_q.len != '0) begin
						if (leaf && !e_q.buf_b) begin
							iss_q   <= '0;
							rv_s1   <= 1'b0;
							state_q <= S_COPY;
						end else if (!leaf) begin
							top_q <= top_q + 1'b1;
						end
					end
				end
				// copy runs on the pass pipeline; its exit is taken above
				S_COPY: ;
				S_POP: begin
					if (top_q == '0) begin
						state_q <= S_DONE;
					end else begin
						top_q   <= top_dec;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					n_q   <= stk_rdata;
					iss_q <= '0;
					rv_s1 <= 1'b0;
					for (int i = 0; i < NUM_BINS; i++) bins_q[i] <= '0;
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					if (rv_s1) bins_q[dig] <= bins_q[dig] + 1'b1;
					if (pass_done) begin
						p_q     <= '0;
						off_q   <= n_q.start;
						state_q <= S_PREFIX;
					end
				end
				S_PREFIX: begin
					first_q[p_q] <= off_q;
					cur_q[p_q]   <= off_q;
					off_q        <= off_q + bins_q[p_q];
					p_q          <= p_q + 1'b1;
					if (p_q == BW'(NUM_BINS - 1)) begin
						iss_q   <= '0;
						rv_s1   <= 1'b0;
						state_q <= S_SCAT;
					end
				end
				S_SCAT: begin
					if (rv_s1) cur_q[dig] <= cur_q[dig] + 1'b1;
					if (pass_done) begin
						child_mode_q <= 1'b1;
						child_q      <= '0;
						e_q.start    <= first_q[0];
						e_q.len      <= bins_q[0];
						e_q.shift    <= n_q.shift - 7'sd3;
						e_q.level    <= n_q.level + 1'b1;
						e_q.buf_b    <= !n_q.buf_b;
						state_q      <= S_ENTER;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);

endmodule

// ===== hw/rtl/truncated_octal_radix_sort_unit.sv =====
// Octree ordering of Morton codes by a truncated MSD radix sort.
// Input channel (in_valid / in_stall): command 0 loads one code and point
// index; the load with last set starts the sort. Command 1 reads one sorted
// position; each read gives one beat on the output channel
// (out_valid / out_stall), none for loads. Loads and reads are accepted
// back to back while in_stall is low; a read result is registered in the
// buffer and level memories and then in the output register. The sort holds
// in_stall high through level store clearing, then per split node through
// pop, count pass, eight-step prefix, scatter pass and one entry step per
// child, and per leaf still in the first buffer through a copy pass.
// Reset empties the batch, sets leaf_threshold 128 and start_shift 60; reads
// before any sort return zeros. While the receiver stalls the output beat
// holds and in_stall rises, so at most one more read waits behind it.
// Configuration is written through cfg_we / cfg_index / cfg_data.
module truncated_octal_radix_sort_unit import tors_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [CODE_BITS-1:0] code,
	input  logic [IDX_W-1:0]     point_index,
	input  logic                 last,
	input  logic [POS_W-1:0]     read_position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_BITS-1:0] sorted_code,
	output logic [IDX_W-1:0]     perm_index,
	output logic [LVL_W-1:0]     node_level,
	output logic                 overflow
);

	logic [THR_W-1:0]   thr_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [CW-1:0]      item_cnt_q;
	logic [CW-1:0]      sorted_cnt_q;
	logic               ovf_q;
	logic               batch_done_q;
	logic               pend_s1;
	logic               hit_s1;
	logic               ovf_s1;

	ram_req_t  eng_a, eng_b, a_req, b_req;
	lvl_req_t  lvl_req;
	eng_stat_t stat;
	mem_word_t a_rdata, b_rdata;
	logic [LVL_W-1:0] lvl_rdata;

	logic          acc, ld_acc, rd_acc, start, out_hold, hit;
	logic [CW-1:0] base, cnt_new;
	logic          room;

	assign out_hold = out_valid && out_stall;
	assign in_stall = stat.busy || out_hold;
	assign acc      = in_valid && !in_stall;
	assign ld_acc   = acc && (command == CMD_LOAD);
	assign rd_acc   = acc && (command == CMD_READ);
	assign start    = ld_acc && last;

	assign base    = batch_done_q ? '0 : item_cnt_q;
	assign room    = (32'(base) < 32'(MAX_ITEMS));
	assign cnt_new = room ? base + 1'b1 : base;
	assign hit     = (32'(read_position) < 32'(sorted_cnt_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			sh_q  <= SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THR:   thr_q <= cfg_data;
				CFG_SHIFT: sh_q  <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// batch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q   <= '0;
			sorted_cnt_q <= '0;
			ovf_q        <= 1'b0;
			batch_done_q <= 1'b0;
		end else begin
			if (ld_acc) begin
				item_cnt_q   <= cnt_new;
				ovf_q        <= (ovf_q && !batch_done_q) || !room;
				batch_done_q <= 1'b0;
				if (batch_done_q) sorted_cnt_q <= '0;
			end
			if (stat.done) begin
				sorted_cnt_q <= item_cnt_q;
				batch_done_q <= 1'b1;
			end
		end
	end

	tors_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.total    (cnt_new),
		.thr      (thr_q),
		.start_sh (sh_q),
		.a_rdata  (a_rdata),
		.b_rdata  (b_rdata),
		.a_req    (eng_a),
		.b_req    (eng_b),
		.lvl_req  (lvl_req),
		.stat     (stat)
	);

	// share buffer ports between host beats and the sort
	always_comb begin
		a_req = eng_a;
		b_req = eng_b;
		if (!stat.busy) begin
			a_req.we         = ld_acc && room;
			a_req.waddr      = base[AW-1:0];
			a_req.wdata.code = code;
			a_req.wdata.idx  = point_index;
			b_req.re         = rd_acc;
			b_req.raddr      = read_position;
		end
	end

	tors_ram #(.DEPTH(MAX_ITEMS), .WIDTH($bits(mem_word_t))) u_buf_a (
		.clk (clk), .we (a_req.we), .waddr (a_req.waddr), .wdata (a_req.wdata),
		.re (a_req.re), .raddr (a_req.raddr), .rdata (a_rdata)
	);

	tors_ram #(.DEPTH(MAX_ITEMS), .WIDTH($bits(mem_word_t))) u_buf_b (
		.clk (clk), .we (b_req.we), .waddr (b_req.waddr), .wdata (b_req.wdata),
		.re (b_req.re), .raddr (b_req.raddr), .rdata (b_rdata)
	);

	tors_ram #(.DEPTH(MAX_ITEMS), .WIDTH(LVL_W)) u_level (
		.clk (clk), .we (lvl_req.we), .waddr (lvl_req.waddr), .wdata (lvl_req.wdata),
		.re (rd_acc), .raddr (read_position), .rdata (lvl_rdata)
	);

	// read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (!out_hold) pend_s1 <= rd_acc;
			if (pend_s1 && !out_hold) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	// read pipeline payload
	always_ff @(posedge clk) begin
		if (rd_acc) begin
			hit_s1 <= hit;
			ovf_s1 <= ovf_q;
		end
		if (pend_s1 && !out_hold) begin
			sorted_code <= hit_s1 ? b_rdata.code : '0;
			perm_index  <= hit_s1 ? b_rdata.idx : '0;
			node_level  <= hit_s1 ? lvl_rdata : '0;
			overflow    <= ovf_s1;
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> stat.busy)
		else $error("sort did not start after last load");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> in_stall)
		else $error("input accepted during sort");

	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && out_hold |=> pend_s1 && out_valid)
		else $error("pending read lost while output stalled");

	a_done_batch: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> batch_done_q && !stat.busy)
		else $error("sort end not recorded");

endmodule
